// File: rtl/sorted_unique_set_assert.svh
// assertion macros used by the set rtl
// each macro expects clk and rst in scope
`ifndef SORTED_UNIQUE_SET_ASSERT_SVH
`define SORTED_UNIQUE_SET_ASSERT_SVH

// same-cycle implication
`define SUS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sorted set check failed");

// next-cycle implication
`define SUS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sorted set check failed");

`endif

// File: rtl/sus_pkg.sv
`timescale 1ns / 1ps
package sus_pkg;

  localparam int CAPACITY_DEF = 64;
  localparam int VALUE_W      = 32;
  localparam int COUNT_W      = 7;

  // command codes
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_DELETE = 1'b1;

  typedef enum logic [1:0] {
    STAT_CHANGED  = 2'd0,
    STAT_NOCHANGE = 2'd1,
    STAT_DROPPED  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_CMP,
    OP_INS,
    OP_DEL,
    OP_ROT
  } cell_op_t;

  typedef struct packed {
    cell_op_t                   op;
    logic signed [VALUE_W-1:0]  value;
  } cell_ctrl_t;

endpackage

// File: rtl/sus_if.sv
`timescale 1ns / 1ps
interface sus_in_if
  import sus_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic                      cmd;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, cmd, value, input ready);
  modport sink   (input valid, cmd, value, output ready);
endinterface

interface sus_out_if
  import sus_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic [COUNT_W-1:0]        count;
  logic                      has_element;
  logic signed [VALUE_W-1:0] element;
  logic [1:0]                status;
  logic                      last;

  modport source (output valid, count, has_element, element, status, last, input ready);
  modport sink   (input valid, count, has_element, element, status, last, output ready);
endinterface

// File: rtl/sus_cell.sv
`timescale 1ns / 1ps
module sus_cell
  import sus_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  cell_ctrl_t                ctrl,
  input  logic signed [VALUE_W-1:0] left_entry,
  input  logic                      left_valid,
  input  logic                      left_lt,
  input  logic signed [VALUE_W-1:0] right_entry,
  input  logic                      right_valid,
  input  logic signed [VALUE_W-1:0] head_entry,
  output logic signed [VALUE_W-1:0] entry,
  output logic                      valid,
  output logic                      lt,
  output logic                      eq
);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      lt    <= 1'b0;
      eq    <= 1'b0;
    end else begin
      unique case (ctrl.op)
        OP_CMP: begin
          lt <= valid && (entry < ctrl.value);
          eq <= valid && (entry == ctrl.value);
        end
        OP_INS: begin
          // cells at or above the insert point move up by one
          if (!lt) begin
            if (left_lt) begin
              entry <= ctrl.value;
              valid <= 1'b1;
            end else begin
              entry <= left_entry;
              valid <= left_valid;
            end
          end
        end
        OP_DEL: begin
          // cells at or above the match close the gap
          if (valid && !lt) begin
            entry <= right_entry;
            valid <= right_valid;
          end
        end
        OP_ROT: begin
          if (valid) begin
            entry <= right_valid ? right_entry : head_entry;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// File: rtl/sorted_unique_set.sv
`timescale 1ns / 1ps
// Sorted set of up to CAPACITY distinct signed 32-bit values, kept as a row of
// cells in ascending order from cell 0 upward. A command on req (cmd 0 insert,
// cmd 1 delete) is taken only while the block is idle. It is compared against
// every cell at once, the row then shifts by one place to open or close a slot,
// and the whole set is streamed out on rsp, smallest first, one item per
// element with last on the final one; an empty set gives one item with
// has_element low. Streaming rotates the row through cell 0, so after count
// shifts the row is back in place. A new command is not taken until the last
// one has gone through accept, compare, shift and read-out, the read-out
// going one element at a time through the single read point at cell 0;
// req ready returns once the block is back in idle. Back-pressure
// on rsp stretches the read-out. Status: 0 set changed, 1 nothing
// to do (value already present on insert, absent on delete), 2 insert dropped
// because the set was full. Count on rsp is the low 7 bits of the element count.
module sorted_unique_set
  import sus_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input logic      clk,
  input logic      rst,
  sus_in_if.sink   req,
  sus_out_if.source rsp
);

  `include "sorted_unique_set_assert.svh"

  localparam int CW = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_UPD,
    S_EMIT
  } state_t;

  state_t                     state;
  logic                       cmd_q;
  logic signed [VALUE_W-1:0]  value_q;
  status_t                    status_q;
  logic [CW-1:0]              count_q;
  logic [CW-1:0]              idx;

  // row of cells
  logic signed [VALUE_W-1:0]  entry_arr [CAPACITY];
  logic [CAPACITY-1:0]        valid_vec;
  logic [CAPACITY-1:0]        lt_vec;
  logic [CAPACITY-1:0]        eq_vec;
  cell_ctrl_t                 cell_ctrl;

  logic present;
  logic full;
  logic emit_fire;
  logic emit_last;
  logic [CAPACITY:0] valid_plus;

  assign present   = |eq_vec;
  assign full      = (count_q == CW'(CAPACITY));
  assign emit_fire = (state == S_EMIT) && (!rsp.valid || rsp.ready);
  assign emit_last = (count_q == '0) || (idx == count_q - CW'(1));
  assign req.ready = (state == S_IDLE);
  assign valid_plus = {1'b0, valid_vec} + (CAPACITY + 1)'(1);

  // operation broadcast to every cell
  always_comb begin
    cell_ctrl.value = value_q;
    cell_ctrl.op    = OP_HOLD;
    unique case (state)
      S_CMP: cell_ctrl.op = OP_CMP;
      S_UPD: begin
        if (cmd_q == CMD_INSERT) begin
          if (!present && !full) cell_ctrl.op = OP_INS;
        end else begin
          if (present) cell_ctrl.op = OP_DEL;
        end
      end
      S_EMIT: begin
        if (emit_fire && count_q != '0) cell_ctrl.op = OP_ROT;
      end
      default: cell_ctrl.op = OP_HOLD;
    endcase
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [VALUE_W-1:0] l_entry;
    logic                      l_valid;
    logic                      l_lt;
    logic signed [VALUE_W-1:0] r_entry;
    logic                      r_valid;

    if (i == 0) begin : g_first
      // insert point is cell 0 when nothing lies below the value
      assign l_entry = '0;
      assign l_valid = 1'b0;
      assign l_lt    = 1'b1;
    end else begin : g_mid
      assign l_entry = entry_arr[i-1];
      assign l_valid = valid_vec[i-1];
      assign l_lt    = lt_vec[i-1];
    end

    if (i == CAPACITY - 1) begin : g_end
      assign r_entry = '0;
      assign r_valid = 1'b0;
    end else begin : g_inner
      assign r_entry = entry_arr[i+1];
      assign r_valid = valid_vec[i+1];
    end

    sus_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctrl        (cell_ctrl),
      .left_entry  (l_entry),
      .left_valid  (l_valid),
      .left_lt     (l_lt),
      .right_entry (r_entry),
      .right_valid (r_valid),
      .head_entry  (entry_arr[0]),
      .entry       (entry_arr[i]),
      .valid       (valid_vec[i]),
      .lt          (lt_vec[i]),
      .eq          (eq_vec[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count_q   <= '0;
      idx       <= '0;
      rsp.valid <= 1'b0;
    end else begin
      // output register drains independently of the command flow
      if (rsp.valid && rsp.ready && !emit_fire) rsp.valid <= 1'b0;

      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            cmd_q   <= req.cmd;
            value_q <= req.value;
            state   <= S_CMP;
          end
        end
        S_CMP: state <= S_UPD;
        S_UPD: begin
          if (cmd_q == CMD_INSERT) begin
            if (present) begin
              status_q <= STAT_NOCHANGE;
            end else if (full) begin
              status_q <= STAT_DROPPED;
            end else begin
              status_q <= STAT_CHANGED;
              count_q  <= count_q + CW'(1);
            end
          end else begin
            if (present) begin
              status_q <= STAT_CHANGED;
              count_q  <= count_q - CW'(1);
            end else begin
              status_q <= STAT_NOCHANGE;
            end
          end
          idx   <= '0;
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (emit_fire) begin
            rsp.valid       <= 1'b1;
            rsp.count       <= COUNT_W'(count_q);
            rsp.has_element <= (count_q != '0);
            rsp.element     <= (count_q != '0) ? entry_arr[0] : '0;
            rsp.status      <= status_q;
            rsp.last        <= emit_last;
            if (emit_last) begin
              idx   <= '0;
              state <= S_IDLE;
            end else begin
              idx <= idx + CW'(1);
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // occupancy never passes the capacity
  `SUS_ASSERT_IMP(a_count_bound, 1'b1, count_q <= CW'(CAPACITY))
  // occupied cells form one run from cell 0
  `SUS_ASSERT_IMP(a_valid_run, 1'b1, $onehot(valid_plus))
  // element counter agrees with the occupied cells between commands
  `SUS_ASSERT_IMP(a_count_match, state == S_IDLE,
                  $countones(valid_vec) == int'(count_q))
  // distinct values give at most one match
  `SUS_ASSERT_IMP(a_single_match, state == S_UPD, $onehot0(eq_vec))
  // final item of a run returns the block to idle
  `SUS_ASSERT_NXT(a_last_idle, emit_fire && emit_last, state == S_IDLE)

endmodule
